### design/paged_memory_and_ula_ports_defines.svh
// Assertion macros shared by the paged memory and port unit.
`ifndef PAGED_MEMORY_AND_ULA_PORTS_DEFINES_SVH
`define PAGED_MEMORY_AND_ULA_PORTS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pmu_pkg.sv
// Types and constants of the paged memory and port unit.
package pmu_pkg;

    localparam int PAGE_AW     = 14;
    localparam int RAM_PAGE_W  = 3;
    localparam int RAM_AW      = PAGE_AW + RAM_PAGE_W;
    localparam int ROM_AW      = PAGE_AW + 1;
    localparam int DATA_W      = 8;
    localparam int KEY_ROWS    = 8;
    localparam int SCREEN_BYTES = 6912;

    localparam logic [DATA_W-1:0] KEY_IDLE    = 8'hBF;
    localparam logic [15:0]       PAGING_MASK = 16'h8002;
    localparam logic [2:0]        SCREEN_NORMAL = 3'd5;
    localparam logic [2:0]        SCREEN_SHADOW = 3'd7;
    localparam logic [2:0]        SLOT1_PAGE    = 3'd5;
    localparam logic [2:0]        SLOT2_PAGE    = 3'd2;
    localparam logic [2:0]        SLOT3_FIXED   = 3'd0;
    localparam logic              ROM_FIXED     = 1'b1;
    localparam logic [2:0]        KEY_BIT_LIMIT = 3'd5;

    localparam logic [1:0] SLOT_ROM = 2'd0;
    localparam logic [1:0] SLOT_1   = 2'd1;
    localparam logic [1:0] SLOT_2   = 2'd2;
    localparam logic [1:0] SLOT_3   = 2'd3;

    typedef enum logic [2:0] {
        CMD_MEM_READ  = 3'd0,
        CMD_MEM_WRITE = 3'd1,
        CMD_IO_READ   = 3'd2,
        CMD_IO_WRITE  = 3'd3,
        CMD_KEY_DOWN  = 3'd4,
        CMD_KEY_UP    = 3'd5,
        CMD_ROM_LOAD  = 3'd6,
        CMD_NOP       = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        RSEL_NONE = 2'd0,
        RSEL_RAM  = 2'd1,
        RSEL_ROM  = 2'd2,
        RSEL_KEY  = 2'd3
    } t_rsel;

    typedef struct packed {
        logic              ram_en;
        logic              ram_we;
        logic [RAM_AW-1:0] ram_addr;
        logic              rom_en;
        logic              rom_we;
        logic [ROM_AW-1:0] rom_addr;
        t_rsel             rsel;
        logic [DATA_W-1:0] key_value;
        logic              contended;
        logic              write_taken;
        logic              screen_touched;
        logic              floating_bus;
    } t_req;

    typedef struct packed {
        logic [2:0] border;
        logic       ear;
        logic [2:0] screen_page;
        logic       locked;
    } t_stat;

endpackage

### design/pmu_mem.sv
// Single-port synchronous byte memory with registered read data.
module pmu_mem import pmu_pkg::*; #(
    parameter int ADDR_W = RAM_AW,
    parameter int WIDTH  = DATA_W
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/pmu_ctrl.sv
// Address mapping, paging register, keyboard rows and port registers.
module pmu_ctrl import pmu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_machine_128k,
    input  logic        i_accept,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [2:0]  i_key_row,
    input  logic [2:0]  i_key_bit,
    output t_req        o_req,
    output t_stat       o_stat
);

    logic              r_machine;
    logic [7:0]        r_preg;
    logic              r_lock;
    logic [2:0]        r_border;
    logic              r_ear;
    logic [DATA_W-1:0] r_key_rows [KEY_ROWS];

    logic              n_machine;
    logic [7:0]        n_preg;
    logic              n_lock;
    logic [2:0]        n_border;
    logic              n_ear;
    logic [DATA_W-1:0] n_key_rows [KEY_ROWS];

    t_cmd              cmd;
    logic [1:0]        slot;
    logic [PAGE_AW-1:0] offset;
    logic [2:0]        ram_page;
    logic              rom_page;
    logic [2:0]        screen_now;
    logic              slot_contended;
    logic [DATA_W-1:0] key_and;
    logic [DATA_W-1:0] key_mask;

    assign cmd    = t_cmd'(i_cmd);
    assign slot   = i_address[15:14];
    assign offset = i_address[PAGE_AW-1:0];

    always_comb begin
        unique case (slot)
            SLOT_1:  ram_page = SLOT1_PAGE;
            SLOT_2:  ram_page = SLOT2_PAGE;
            default: ram_page = r_machine ? r_preg[2:0] : SLOT3_FIXED;
        endcase
    end

    assign rom_page       = r_machine ? r_preg[4] : ROM_FIXED;
    assign screen_now     = (r_machine && r_preg[3]) ? SCREEN_SHADOW : SCREEN_NORMAL;
    assign slot_contended = (slot == SLOT_1) || (r_machine && slot == SLOT_3 && r_preg[0]);
    assign key_mask       = 8'(1) << i_key_bit;

    always_comb begin
        key_and = KEY_IDLE;
        for (int i = 0; i < KEY_ROWS; i++) begin
            if (!i_address[8+i]) begin
                key_and = key_and & r_key_rows[i];
            end
        end
    end

    always_comb begin
        n_machine  = r_machine;
        n_preg     = r_preg;
        n_lock     = r_lock;
        n_border   = r_border;
        n_ear      = r_ear;
        n_key_rows = r_key_rows;
        o_req      = '0;
        o_req.rsel = RSEL_NONE;
        o_req.ram_addr = {ram_page, offset};
        o_req.rom_addr = {rom_page, offset};
        o_req.key_value = key_and;
        if (i_cfg_we) begin
            n_machine = i_cfg_machine_128k;
            n_preg    = '0;
            n_lock    = 1'b0;
        end
        if (i_accept) begin
            unique case (cmd)
                CMD_MEM_READ: begin
                    o_req.contended = slot_contended;
                    if (slot == SLOT_ROM) begin
                        o_req.rom_en = 1'b1;
                        o_req.rsel   = RSEL_ROM;
                    end else begin
                        o_req.ram_en = 1'b1;
                        o_req.rsel   = RSEL_RAM;
                    end
                end
                CMD_MEM_WRITE: begin
                    o_req.contended = slot_contended;
                    if (slot != SLOT_ROM) begin
                        o_req.ram_en      = 1'b1;
                        o_req.ram_we      = 1'b1;
                        o_req.write_taken = 1'b1;
                        o_req.screen_touched = (ram_page == screen_now) &&
                                               (offset < PAGE_AW'(SCREEN_BYTES));
                    end
                end
                CMD_IO_READ: begin
                    if (!i_address[0]) begin
                        o_req.rsel = RSEL_KEY;
                    end else begin
                        o_req.floating_bus = 1'b1;
                    end
                end
                CMD_IO_WRITE: begin
                    if (r_machine && (i_address & PAGING_MASK) == 16'h0000 && !r_lock) begin
                        n_preg = i_data;
                        n_lock = i_data[5];
                    end
                    if (!i_address[0]) begin
                        n_border = i_data[2:0];
                        n_ear    = i_data[4];
                    end
                end
                CMD_KEY_DOWN: begin
                    if (i_key_bit < KEY_BIT_LIMIT) begin
                        n_key_rows[i_key_row] = r_key_rows[i_key_row] & ~key_mask;
                    end
                end
                CMD_KEY_UP: begin
                    if (i_key_bit < KEY_BIT_LIMIT) begin
                        n_key_rows[i_key_row] = r_key_rows[i_key_row] | key_mask;
                    end
                end
                CMD_ROM_LOAD: begin
                    o_req.rom_en   = 1'b1;
                    o_req.rom_we   = 1'b1;
                    o_req.rom_addr = i_address[ROM_AW-1:0];
                end
                default: begin
                end
            endcase
        end
        o_stat.border      = n_border;
        o_stat.ear         = n_ear;
        o_stat.screen_page = (n_machine && n_preg[3]) ? SCREEN_SHADOW : SCREEN_NORMAL;
        o_stat.locked      = n_lock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine <= 1'b0;
            r_preg    <= '0;
            r_lock    <= 1'b0;
            r_border  <= '0;
            r_ear     <= 1'b0;
            for (int i = 0; i < KEY_ROWS; i++) begin
                r_key_rows[i] <= KEY_IDLE;
            end
        end else begin
            r_machine  <= n_machine;
            r_preg     <= n_preg;
            r_lock     <= n_lock;
            r_border   <= n_border;
            r_ear      <= n_ear;
            r_key_rows <= n_key_rows;
        end
    end

endmodule

### design/paged_memory_and_ula_ports.sv
// Top level: bank-switched 16K page mapper with keyboard, border and paging ports.
// An accepted word is registered in the first stage, then in the output register.
// Throughput: one word per cycle while the output side does not stall.
// RAM and ROM reads start at the accepting edge; the output register takes them as stage one moves.
// Reset clears mapping mode, paging register, lock, border, ear and keyboard rows to idle.
// RAM and ROM contents are not cleared by reset and must be written before they are read.
`include "paged_memory_and_ula_ports_defines.svh"

module paged_memory_and_ula_ports import pmu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_machine_128k,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [2:0]  i_key_row,
    input  logic [2:0]  i_key_bit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_contended,
    output logic        o_write_taken,
    output logic        o_screen_touched,
    output logic        o_floating_bus,
    output logic [2:0]  o_border_color,
    output logic        o_ear_bit,
    output logic [2:0]  o_screen_page,
    output logic        o_paging_locked
);

    t_req              req;
    t_stat             stat;
    logic              accept;
    logic              s1_move;
    logic [DATA_W-1:0] ram_q;
    logic [DATA_W-1:0] rom_q;

    logic              r_s1_valid;
    t_rsel             r_s1_rsel;
    logic [DATA_W-1:0] r_s1_key;
    logic [3:0]        r_s1_flags;
    t_stat             r_s1_stat;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [3:0]        r_out_flags;
    t_stat             r_out_stat;

    logic [DATA_W-1:0] n_out_data;

    assign o_cfg_ready = 1'b1;
    assign s1_move     = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_s1_valid && !s1_move;
    assign accept      = i_valid && !o_stall;

    pmu_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_machine_128k (i_cfg_machine_128k),
        .i_accept           (accept),
        .i_cmd              (i_cmd),
        .i_address          (i_address),
        .i_data             (i_data),
        .i_key_row          (i_key_row),
        .i_key_bit          (i_key_bit),
        .o_req              (req),
        .o_stat             (stat)
    );

    pmu_mem #(.ADDR_W(RAM_AW), .WIDTH(DATA_W)) u_ram (
        .i_clk   (i_clk),
        .i_en    (req.ram_en),
        .i_we    (req.ram_we),
        .i_addr  (req.ram_addr),
        .i_wdata (i_data),
        .o_rdata (ram_q)
    );

    pmu_mem #(.ADDR_W(ROM_AW), .WIDTH(DATA_W)) u_rom (
        .i_clk   (i_clk),
        .i_en    (req.rom_en),
        .i_we    (req.rom_we),
        .i_addr  (req.rom_addr),
        .i_wdata (i_data),
        .o_rdata (rom_q)
    );

    always_comb begin
        case (r_s1_rsel)
            RSEL_RAM: n_out_data = ram_q;
            RSEL_ROM: n_out_data = rom_q;
            RSEL_KEY: n_out_data = r_s1_key;
            default:  n_out_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rsel  <= req.rsel;
            r_s1_key   <= req.key_value;
            r_s1_flags <= {req.contended, req.write_taken, req.screen_touched,
                           req.floating_bus};
            r_s1_stat  <= stat;
        end
        if (s1_move) begin
            r_out_data  <= n_out_data;
            r_out_flags <= r_s1_flags;
            r_out_stat  <= r_s1_stat;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_read_data      = r_out_data;
    assign o_contended      = r_out_flags[3];
    assign o_write_taken    = r_out_flags[2];
    assign o_screen_touched = r_out_flags[1];
    assign o_floating_bus   = r_out_flags[0];
    assign o_border_color   = r_out_stat.border;
    assign o_ear_bit        = r_out_stat.ear;
    assign o_screen_page    = r_out_stat.screen_page;
    assign o_paging_locked  = r_out_stat.locked;

    `PMU_ASSERT_SAME(a_screen_page_legal, o_valid, (o_screen_page == SCREEN_NORMAL) || (o_screen_page == SCREEN_SHADOW), "screen page is neither normal nor shadow")
    `PMU_ASSERT_SAME(a_touch_needs_write, o_valid && o_screen_touched, o_write_taken, "screen flagged without a RAM write")
    `PMU_ASSERT_SAME(a_no_data_on_write, o_valid && (o_write_taken || o_floating_bus), o_read_data == 8'h00, "read data not zero for write or floating bus")
    `PMU_ASSERT_NEXT(a_item_reaches_output, s1_move, r_out_valid, "item left first stage but no result appeared")

endmodule
